/* rtl/rld_pkg.sv */
// rld_pkg: widths, constants and the command/status types shared by the
// relative l2 difference controller, datapath and top level. no dependencies
`timescale 1ns / 1ps

package rld_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int COUNT_BITS    = 20;
   localparam int DIFF_SQ_BITS  = 2 * SAMPLE_BITS;
   localparam int OLD_SQ_BITS   = 2 * SAMPLE_BITS - 1;
   localparam int DIFF_SUM_BITS = 2 * SAMPLE_BITS + COUNT_BITS + 1;
   localparam int OLD_SUM_BITS  = 2 * SAMPLE_BITS + COUNT_BITS - 1;

   localparam int OUT_INT_BITS  = 8;
   localparam int OUT_FRAC_BITS = 16;
   localparam int OUT_BITS      = OUT_INT_BITS + OUT_FRAC_BITS;
   localparam int SAT_SHIFT     = 2 * OUT_INT_BITS;
   localparam int QUO_BITS      = 2 * OUT_BITS;
   localparam int ROOT_BITS     = OUT_BITS;
   localparam int REM_BITS      = OLD_SUM_BITS + 1;
   localparam int SREM_BITS     = ROOT_BITS + 2;
   localparam int STEP_BITS     = $clog2(QUO_BITS);

   localparam int REQ_DATA_BITS = 2 * SAMPLE_BITS;
   localparam int RSP_DATA_BITS = OUT_BITS;
   localparam int RSP_USER_BITS = 2;

   typedef struct packed {
      logic accept;
      logic check;
      logic div_step;
      logic sqrt_step;
      logic load_out;
   } rld_cmd_type;

   typedef struct packed {
      logic special;
   } rld_status_type;

endpackage

/* rtl/rld_ctrl.sv */
// rld_ctrl: sequencer for accumulate, range check, long division and root
// steps, plus the result valid flag. depends on rld_pkg
`timescale 1ns / 1ps

module rld_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  rld_pkg::rld_status_type status,
   output rld_pkg::rld_cmd_type    cmd
);
   import rld_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_SQRT,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_tvalid;
      cmd.check     = (state_ff == ST_CHECK);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.load_out  = (state_ff == ST_FINISH) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tlast) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            count_in = '0;
            state_in = status.special ? ST_FINISH : ST_DIV;
         end
         ST_DIV: begin
            if (count_ff == STEP_BITS'(QUO_BITS - 1)) begin
               count_in = '0;
               state_in = ST_SQRT;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            if (count_ff == STEP_BITS'(ROOT_BITS - 1)) begin
               count_in = '0;
               state_in = ST_FINISH;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (count_ff < STEP_BITS'(QUO_BITS)))
      else $error("division step count out of range");

   a_sqrt_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> (count_ff < STEP_BITS'(ROOT_BITS)))
      else $error("root step count out of range");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (state_ff == ST_CHECK))
      else $error("last item did not start evaluation");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == ST_FINISH && rsp_valid_ff))
      else $error("pending result overwritten");
`endif

endmodule

/* rtl/rld_datapath.sv */
// rld_datapath: saturating square accumulators, restoring long divider,
// bit-pair square root and result register. depends on rld_pkg
`timescale 1ns / 1ps

module rld_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rld_pkg::rld_cmd_type                 cmd,
   output rld_pkg::rld_status_type              status,
   input  logic [rld_pkg::SAMPLE_BITS-1:0]      new_value,
   input  logic [rld_pkg::SAMPLE_BITS-1:0]      old_value,
   input  logic                                 last_element,
   output logic [rld_pkg::OUT_BITS-1:0]         relative_diff,
   output logic                                 zero_reference,
   output logic                                 saturated
);
   import rld_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   logic [DIFF_SUM_BITS-1:0] diff_acc_ff, diff_acc_in;
   logic [OLD_SUM_BITS-1:0]  old_acc_ff, old_acc_in;
   logic [DIFF_SUM_BITS-1:0] num_ff;
   logic [OLD_SUM_BITS-1:0]  den_ff;
   logic [REM_BITS-1:0]      rem_ff;
   logic [QUO_BITS-1:0]      quo_ff;
   logic [SREM_BITS-1:0]     srem_ff;
   logic [ROOT_BITS-1:0]     root_ff;
   logic                     zero_ff;
   logic                     sat_ff;
   logic [OUT_BITS-1:0]      rel_ff;
   logic                     zero_out_ff;
   logic                     sat_out_ff;

   logic [SAMPLE_BITS-1:0]   a_off, b_off, gap, mag;
   logic [DIFF_SQ_BITS-1:0]  diff_sq;
   logic [2*SAMPLE_BITS-1:0] old_sq_full;
   logic [DIFF_SUM_BITS:0]   diff_sum;
   logic [OLD_SUM_BITS:0]    old_sum;
   logic [DIFF_SUM_BITS-1:0] diff_next;
   logic [OLD_SUM_BITS-1:0]  old_next;
   logic                     zero_c, sat_c;
   logic [REM_BITS-1:0]      rem_shift;
   logic                     div_ge;
   logic [SREM_BITS-1:0]     srem_shift, trial;
   logic                     sqrt_ge;

   // sample pair to squared terms
   always_comb begin
      a_off       = new_value ^ SIGN_BIT;
      b_off       = old_value ^ SIGN_BIT;
      gap         = (a_off >= b_off) ? (a_off - b_off) : (b_off - a_off);
      mag         = old_value[SAMPLE_BITS-1] ? (~old_value + 1'b1) : old_value;
      diff_sq     = gap * gap;
      old_sq_full = mag * mag;
      diff_sum    = {1'b0, diff_acc_ff} + (DIFF_SUM_BITS + 1)'(diff_sq);
      old_sum     = {1'b0, old_acc_ff}
                    + (OLD_SUM_BITS + 1)'(old_sq_full[OLD_SQ_BITS-1:0]);
      diff_next   = diff_sum[DIFF_SUM_BITS] ? '1 : diff_sum[DIFF_SUM_BITS-1:0];
      old_next    = old_sum[OLD_SUM_BITS] ? '1 : old_sum[OLD_SUM_BITS-1:0];
   end

   always_comb begin
      diff_acc_in = diff_acc_ff;
      old_acc_in  = old_acc_ff;
      if (cmd.accept) begin
         diff_acc_in = last_element ? '0 : diff_next;
         old_acc_in  = last_element ? '0 : old_next;
      end
   end

   // range check on the captured sums
   assign zero_c         = (den_ff == '0);
   assign sat_c          = !zero_c
                           && (REM_BITS'(num_ff >> SAT_SHIFT) >= REM_BITS'(den_ff));
   assign status.special = zero_c || sat_c;

   // one quotient bit per step
   assign rem_shift = {rem_ff[REM_BITS-2:0], quo_ff[QUO_BITS-1]};
   assign div_ge    = (rem_shift >= REM_BITS'(den_ff));

   // one root bit per step
   assign srem_shift = {srem_ff[SREM_BITS-3:0], quo_ff[QUO_BITS-1:QUO_BITS-2]};
   assign trial      = {root_ff, 2'b01};
   assign sqrt_ge    = (srem_shift >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_acc_ff <= '0;
         old_acc_ff  <= '0;
      end else begin
         diff_acc_ff <= diff_acc_in;
         old_acc_ff  <= old_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && last_element) begin
         num_ff <= diff_next;
         den_ff <= old_next;
      end
      if (cmd.check) begin
         zero_ff <= zero_c;
         sat_ff  <= sat_c;
         rem_ff  <= REM_BITS'(num_ff >> SAT_SHIFT);
         quo_ff  <= {num_ff[SAT_SHIFT-1:0], {(QUO_BITS - SAT_SHIFT){1'b0}}};
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? (rem_shift - REM_BITS'(den_ff)) : rem_shift;
         quo_ff <= {quo_ff[QUO_BITS-2:0], div_ge};
      end else if (cmd.sqrt_step) begin
         srem_ff <= sqrt_ge ? (srem_shift - trial) : srem_shift;
         root_ff <= {root_ff[ROOT_BITS-2:0], sqrt_ge};
         quo_ff  <= {quo_ff[QUO_BITS-3:0], 2'b00};
      end
      if (cmd.load_out) begin
         rel_ff      <= sat_ff ? '1 : (zero_ff ? '0 : root_ff);
         zero_out_ff <= zero_ff;
         sat_out_ff  <= sat_ff;
      end
   end

   assign relative_diff  = rel_ff;
   assign zero_reference = zero_out_ff;
   assign saturated      = sat_out_ff;

endmodule

/* rtl/relative_l2_difference_core.sv */
// relative_l2_difference_core: top level, joins controller and datapath and
// packs the stream channels. depends on rld_pkg, rld_ctrl, rld_datapath
`timescale 1ns / 1ps
//
// each req item carries one new/old element pair in signed q2.14; tlast
// marks the final pair of a vector. pairs are accepted one per cycle and
// folded into saturating sums of squared differences and squared old values.
// after the last pair the input stalls (req_tready low) while the block
// checks for a zero reference or an oversized ratio, then runs a 48 step
// long division of the difference sum over the old sum, one quotient bit
// per cycle, and a 24 step square root, one root bit per cycle.
// a normal vector end loads its result after the root steps; a zero
// reference or saturation skips the division and root and goes from the
// check straight to the result load. the next item is accepted in the
// cycle after the result is loaded.
// the result sits in an output register; while the receiver stalls it holds
// and the block keeps taking items, stalling only if a second result is
// ready before the first is taken.
// reset clears both sums and drops any pending result.
//

module relative_l2_difference_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // new_value [15:0], old_value [31:16]
   input  logic [rld_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // relative_diff [23:0]
   output logic [rld_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // zero_reference [0], saturated [1]
   output logic [rld_pkg::RSP_USER_BITS-1:0] rsp_tuser
);
   import rld_pkg::*;

   rld_cmd_type    cmd;
   rld_status_type status;
   logic           zero_reference;
   logic           saturated;

   rld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rld_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .new_value      (req_tdata[SAMPLE_BITS-1:0]),
      .old_value      (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .last_element   (req_tlast),
      .relative_diff  (rsp_tdata),
      .zero_reference (zero_reference),
      .saturated      (saturated)
   );

   assign rsp_tuser = {saturated, zero_reference};

endmodule
